// ===== hw/rtl/bcss_pkg.sv =====
package bcss_pkg;

   // Default geometry of a frame.
   localparam int SYMBOLS_DEF   = 40;
   localparam int MAX_SHIFT_DEF = 8;
   localparam int GROUPS_DEF    = 5;

   // Widths of the result fields.
   localparam int CODE_W  = 8;
   localparam int AGREE_W = 3;
   localparam int SPEED_W = 14;

   // Bits per group and per nibble.
   localparam int GROUP_BITS = 8;
   localparam int NIB_W      = 4;

   // Smallest number of agreeing groups that accepts a shift.
   localparam int MIN_AGREE = 2;

   // Result of looking a byte up in the codeword table.
   typedef struct packed {
      logic             hit;
      logic [NIB_W-1:0] val;
   } nib_dec_type;

   // The sixteen Bauer (8,4) codewords, indexed by their 4-bit value.
   localparam logic [GROUP_BITS-1:0] BAUER_WORDS [16] = '{
      8'h01, 8'h1f, 8'h2c, 8'h32, 8'h4a, 8'h54, 8'h67, 8'h79,
      8'h86, 8'h98, 8'hab, 8'hb5, 8'hcd, 8'hd3, 8'he0, 8'hfe
   };

   // Speed pairs, indexed by the low six bits of the code.
   localparam logic [SPEED_W-1:0] SPEED_TABLE [64] = '{
      14'd9999, 14'd8080, 14'd8070, 14'd8065, 14'd8060, 14'd7070, 14'd7065, 14'd7060,
      14'd7055, 14'd7050, 14'd6565, 14'd6560, 14'd6555, 14'd6550, 14'd6545, 14'd6540,
      14'd6500, 14'd6060, 14'd6055, 14'd6050, 14'd6045, 14'd6040, 14'd6000, 14'd5555,
      14'd5550, 14'd5545, 14'd5540, 14'd5535, 14'd5500, 14'd5050, 14'd5045, 14'd5040,
      14'd5035, 14'd5020, 14'd5000, 14'd4545, 14'd4540, 14'd4535, 14'd4520, 14'd4500,
      14'd4040, 14'd4035, 14'd4020, 14'd4000, 14'd3535, 14'd3520, 14'd3515, 14'd3500,
      14'd2020, 14'd2015, 14'd2000, 14'd1515, 14'd1500, 14'd0,    14'd3535, 14'd3520,
      14'd3515, 14'd3500, 14'd2020, 14'd2015, 14'd2000, 14'd1500, 14'd1505, 14'd500
   };

   // Looks a byte up in the codeword table; hit is low for a non-codeword.
   function automatic nib_dec_type bauer_decode(input logic [GROUP_BITS-1:0] b);
      nib_dec_type r;
      r = '0;
      for (int k = 0; k < 16; k++) begin
         if (BAUER_WORDS[k] == b) begin
            r.hit = 1'b1;
            r.val = NIB_W'(k);
         end
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/bauer_codeword_shift_search.sv =====
// A word accepted on req_ is registered in the decode, agreement and selection stages
// in that order before it is offered on rsp_.
// Throughput: one frame per cycle; the three register stages (codeword
// decode, per-shift agreement count, shift selection with speed lookup)
// each take a new frame when empty or whenever the stage after them moves.
// Reset (synchronous, active high) empties all stages; no frame is in flight.
module bauer_codeword_shift_search #(
   parameter int SYMBOLS   = bcss_pkg::SYMBOLS_DEF,
   parameter int MAX_SHIFT = bcss_pkg::MAX_SHIFT_DEF,
   parameter int GROUPS    = bcss_pkg::GROUPS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [SYMBOLS-1:0]           req_high_bits,
   input  logic [SYMBOLS-1:0]           req_low_bits,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_decode_failed,
   output logic [bcss_pkg::CODE_W-1:0]  rsp_code,
   output logic [bcss_pkg::AGREE_W-1:0] rsp_agree_count,
   output logic [bcss_pkg::SPEED_W-1:0] rsp_speed_limit
);
   import bcss_pkg::*;

   localparam int CNT_W = $clog2(GROUPS + 1);

   // Stage advance controls.
   logic adv1, adv2, adv3;

   // Stage 1: decoded group values for every shift.
   logic                  s1_valid_ff;
   logic [CODE_W-1:0]     dec_code_in  [MAX_SHIFT][GROUPS];
   logic                  dec_hit_in   [MAX_SHIFT][GROUPS];
   logic [CODE_W-1:0]     s1_code_ff   [MAX_SHIFT][GROUPS];
   logic                  s1_hit_ff    [MAX_SHIFT][GROUPS];

   // Stage 2: first valid group and agreement count for every shift.
   logic                  s2_valid_ff;
   logic [CODE_W-1:0]     s2_first_in  [MAX_SHIFT];
   logic [CNT_W-1:0]      s2_cnt_in    [MAX_SHIFT];
   logic [CODE_W-1:0]     s2_first_ff  [MAX_SHIFT];
   logic [CNT_W-1:0]      s2_cnt_ff    [MAX_SHIFT];

   // Stage 3: selected result.
   logic                  s3_valid_ff;
   logic                  failed_in, failed_ff;
   logic [CODE_W-1:0]     code_in, code_ff;
   logic [AGREE_W-1:0]    agree_in, agree_ff;
   logic [SPEED_W-1:0]    speed_in, speed_ff;

   // A stage moves when it is empty or the stage after it moves.
   assign adv3      = !s3_valid_ff || rsp_ready;
   assign adv2      = !s2_valid_ff || adv3;
   assign adv1      = !s1_valid_ff || adv2;
   assign req_ready = adv1;

   // Gather and decode the bytes of each group at each shift.
   for (genvar s = 0; s < MAX_SHIFT; s++) begin : g_shift
      for (genvar g = 0; g < GROUPS; g++) begin : g_group
         if ((g * GROUP_BITS >= s) && (g * GROUP_BITS + GROUP_BITS <= SYMBOLS)) begin : g_live
            localparam int FIRST = g * GROUP_BITS - s;
            logic [GROUP_BITS-1:0] byte_hi, byte_lo;
            nib_dec_type           nib_hi, nib_lo;
            // The symbol at the lowest position becomes the MSB.
            for (genvar j = 0; j < GROUP_BITS; j++) begin : g_bit
               assign byte_hi[GROUP_BITS-1-j] = req_high_bits[FIRST+j];
               assign byte_lo[GROUP_BITS-1-j] = req_low_bits[FIRST+j];
            end
            assign nib_hi              = bauer_decode(byte_hi);
            assign nib_lo              = bauer_decode(byte_lo);
            assign dec_hit_in[s][g]    = nib_hi.hit && nib_lo.hit;
            assign dec_code_in[s][g]   = {nib_hi.val, nib_lo.val};
         end else begin : g_dead
            // The group reaches before the shift or past the frame.
            assign dec_hit_in[s][g]    = 1'b0;
            assign dec_code_in[s][g]   = '0;
         end
      end
   end

   // Count groups that agree with the first valid group, per shift.
   always_comb begin
      logic [CNT_W-1:0]  cnt;
      logic [CODE_W-1:0] first;
      for (int s = 0; s < MAX_SHIFT; s++) begin
         cnt   = '0;
         first = '0;
         for (int g = 0; g < GROUPS; g++) begin
            if (s1_hit_ff[s][g]) begin
               if (cnt == '0) begin
                  first = s1_code_ff[s][g];
                  cnt   = CNT_W'(1);
               end else if (s1_code_ff[s][g] == first) begin
                  cnt = cnt + CNT_W'(1);
               end
            end
         end
         s2_first_in[s] = first;
         s2_cnt_in[s]   = cnt;
      end
   end

   // Pick the lowest qualifying shift, swap nibbles and look up the speeds.
   always_comb begin
      logic [CODE_W-1:0] pick;
      logic [CNT_W-1:0]  pick_cnt;
      logic              found;
      pick     = '0;
      pick_cnt = '0;
      found    = 1'b0;
      for (int s = MAX_SHIFT - 1; s >= 0; s--) begin
         if (s2_cnt_ff[s] >= CNT_W'(MIN_AGREE)) begin
            found    = 1'b1;
            pick     = s2_first_ff[s];
            pick_cnt = s2_cnt_ff[s];
         end
      end
      failed_in = !found;
      code_in   = found ? {pick[NIB_W-1:0], pick[CODE_W-1:NIB_W]} : '0;
      agree_in  = found ? AGREE_W'(pick_cnt) : '0;
      speed_in  = found ? SPEED_TABLE[code_in[5:0]] : '0;
   end

   // Valid bits of the three stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (adv1) s1_valid_ff <= req_valid;
         if (adv2) s2_valid_ff <= s1_valid_ff;
         if (adv3) s3_valid_ff <= s2_valid_ff;
      end
   end

   // Payload registers of the three stages.
   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_code_ff <= dec_code_in;
         s1_hit_ff  <= dec_hit_in;
      end
      if (adv2) begin
         s2_first_ff <= s2_first_in;
         s2_cnt_ff   <= s2_cnt_in;
      end
      if (adv3) begin
         failed_ff <= failed_in;
         code_ff   <= code_in;
         agree_ff  <= agree_in;
         speed_ff  <= speed_in;
      end
   end

   assign rsp_valid         = s3_valid_ff;
   assign rsp_decode_failed = failed_ff;
   assign rsp_code          = code_ff;
   assign rsp_agree_count   = agree_ff;
   assign rsp_speed_limit   = speed_ff;

   // A failed frame carries all-zero fields.
   a_fail_zero : assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff && failed_ff |-> code_ff == '0 && agree_ff == '0 && speed_ff == '0)
      else $error("failed word carries nonzero fields");

   // An accepted word always lands in the first stage.
   a_accept_lands : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> s1_valid_ff)
      else $error("accepted word lost at stage one");

   // A blocked stage keeps its word.
   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !adv3 |=> s2_valid_ff && s3_valid_ff)
      else $error("word dropped while stage two was blocked");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import bcss_pkg::*;

   localparam int SYM         = SYMBOLS_DEF;
   localparam int SHIFTS      = MAX_SHIFT_DEF;
   localparam int NGROUPS     = GROUPS_DEF;
   localparam int RANDOM_WORDS = 700;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 64;
   localparam int MAX_REPORTS = 200;

   // Receiver stall patterns.
   typedef enum int {
      ALWAYS_READY,
      COIN_FLIP,
      MOSTLY_STALLED,
      MASK_ROTATE
   } stall_mode_type;

   // One frame of symbol bit pairs.
   typedef struct packed {
      logic [SYM-1:0] hi;
      logic [SYM-1:0] lo;
   } frame_type;

   // Decoded result of one frame.
   typedef struct packed {
      logic               failed;
      logic [CODE_W-1:0]  code;
      logic [AGREE_W-1:0] agree;
      logic [SPEED_W-1:0] speed;
   } decode_type;

   // Codeword list, indexed by the nibble it carries.
   localparam logic [7:0] CODEWORD [16] = '{
      8'h01, 8'h1f, 8'h2c, 8'h32, 8'h4a, 8'h54, 8'h67, 8'h79,
      8'h86, 8'h98, 8'hab, 8'hb5, 8'hcd, 8'hd3, 8'he0, 8'hfe
   };

   // Speed pairs, indexed by the low six bits of the code.
   localparam logic [SPEED_W-1:0] SPEED_PAIR [64] = '{
      14'd9999, 14'd8080, 14'd8070, 14'd8065, 14'd8060, 14'd7070, 14'd7065, 14'd7060,
      14'd7055, 14'd7050, 14'd6565, 14'd6560, 14'd6555, 14'd6550, 14'd6545, 14'd6540,
      14'd6500, 14'd6060, 14'd6055, 14'd6050, 14'd6045, 14'd6040, 14'd6000, 14'd5555,
      14'd5550, 14'd5545, 14'd5540, 14'd5535, 14'd5500, 14'd5050, 14'd5045, 14'd5040,
      14'd5035, 14'd5020, 14'd5000, 14'd4545, 14'd4540, 14'd4535, 14'd4520, 14'd4500,
      14'd4040, 14'd4035, 14'd4020, 14'd4000, 14'd3535, 14'd3520, 14'd3515, 14'd3500,
      14'd2020, 14'd2015, 14'd2000, 14'd1515, 14'd1500, 14'd0,    14'd3535, 14'd3520,
      14'd3515, 14'd3500, 14'd2020, 14'd2015, 14'd2000, 14'd1500, 14'd1505, 14'd500
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid     = 1'b0;
   logic               req_ready;
   logic [SYM-1:0]     req_high_bits = '0;
   logic [SYM-1:0]     req_low_bits  = '0;
   logic               rsp_valid;
   logic               rsp_ready     = 1'b0;
   logic               rsp_decode_failed;
   logic [CODE_W-1:0]  rsp_code;
   logic [AGREE_W-1:0] rsp_agree_count;
   logic [SPEED_W-1:0] rsp_speed_limit;

   frame_type  pending_frames [$];
   decode_type predicted_decodes [$];

   int             error_count   = 0;
   int             cycle_count   = 0;
   int             burst_left    = 0;
   int             gap_left      = 0;
   int             hold_left     = 0;
   int             holds_done    = 0;
   int             stall_cycles  = 0;
   int             pattern_left  = 0;
   stall_mode_type pattern_mode  = ALWAYS_READY;
   logic [7:0]     ready_mask    = 8'hff;
   logic           long_hold     = 1'b0;

   bauer_codeword_shift_search i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_high_bits     (req_high_bits),
      .req_low_bits      (req_low_bits),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_decode_failed (rsp_decode_failed),
      .rsp_code          (rsp_code),
      .rsp_agree_count   (rsp_agree_count),
      .rsp_speed_limit   (rsp_speed_limit)
   );

   always #2 clock = ~clock;

   // Returns the nibble of a codeword, or -1 for any other byte.
   function automatic int codeword_nibble(logic [7:0] b);
      for (int k = 0; k < 16; k++) begin
         if (CODEWORD[k] == b) return k;
      end
      return -1;
   endfunction

   // Searches the shifts in order and decodes the first one with at least two agreeing groups.
   function automatic decode_type decode_frame(frame_type f);
      decode_type r;
      logic [7:0] hb, lb;
      int         dh, dl, count, first, cur, base;
      r = '0;
      r.failed = 1'b1;
      for (int s = 0; s < SHIFTS; s++) begin
         count = 0;
         first = 0;
         for (int g = 0; g < NGROUPS; g++) begin
            // A group that starts before the shift or runs off the frame holds no byte.
            if (g * GROUP_BITS < s || g * GROUP_BITS + GROUP_BITS > SYM) continue;
            base = g * GROUP_BITS - s;
            for (int j = 0; j < GROUP_BITS; j++) begin
               hb[7-j] = f.hi[base+j];
               lb[7-j] = f.lo[base+j];
            end
            dh = codeword_nibble(hb);
            dl = codeword_nibble(lb);
            if (dh < 0 || dl < 0) continue;
            cur = dh * 16 + dl;
            if (count == 0) begin
               first = cur;
               count = 1;
            end else if (cur == first) begin
               count++;
            end
         end
         if (count >= MIN_AGREE) begin
            r.failed = 1'b0;
            r.code   = {first[3:0], first[7:4]};
            r.agree  = AGREE_W'(count);
            r.speed  = SPEED_PAIR[r.code[5:0]];
            return r;
         end
      end
      return r;
   endfunction

   function automatic logic [SYM-1:0] random_symbols();
      return SYM'({$urandom, $urandom});
   endfunction

   // Writes a byte MSB first into the symbols starting at base.
   function automatic logic [SYM-1:0] put_byte(logic [SYM-1:0] v, int base, logic [7:0] b);
      for (int j = 0; j < GROUP_BITS; j++) v[base+j] = b[7-j];
      return v;
   endfunction

   // Builds a frame that carries one code in n_agree groups at the given shift.
   // Other groups get random codewords when mixed is set; the background is
   // random when noisy is set and all zeros otherwise.
   function automatic frame_type build_frame(int shift, int hi_nib, int lo_nib, int n_agree,
                                             bit mixed, bit noisy);
      frame_type f;
      int        order [NGROUPS];
      int        first_g, n_valid, k, tmp, g;
      f.hi = noisy ? random_symbols() : '0;
      f.lo = noisy ? random_symbols() : '0;
      first_g = (shift > 0) ? 1 : 0;
      n_valid = NGROUPS - first_g;
      for (int i = 0; i < n_valid; i++) order[i] = first_g + i;
      // Shuffle so that the agreeing groups land anywhere in the frame.
      for (int i = n_valid - 1; i > 0; i--) begin
         k = $urandom_range(0, i);
         tmp = order[i];
         order[i] = order[k];
         order[k] = tmp;
      end
      for (int i = 0; i < n_valid; i++) begin
         g = order[i];
         if (i < n_agree) begin
            f.hi = put_byte(f.hi, g * GROUP_BITS - shift, CODEWORD[hi_nib]);
            f.lo = put_byte(f.lo, g * GROUP_BITS - shift, CODEWORD[lo_nib]);
         end else if (mixed) begin
            f.hi = put_byte(f.hi, g * GROUP_BITS - shift, CODEWORD[$urandom_range(0, 15)]);
            f.lo = put_byte(f.lo, g * GROUP_BITS - shift, CODEWORD[$urandom_range(0, 15)]);
         end
      end
      return f;
   endfunction

   task automatic check_field(input string field, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         error_count++;
         if (error_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   // Driver: offers queued frames in bursts and records the decode of each accepted word.
   always @(posedge clock) begin : drive_proc
      frame_type nxt;
      frame_type taken;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            taken.hi = req_high_bits;
            taken.lo = req_low_bits;
            predicted_decodes.push_back(decode_frame(taken));
         end
         if (req_valid && !req_ready) begin
            // Hold the word until it is taken.
         end else if (gap_left > 0 && !long_hold) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_frames.size() > 0) begin
            nxt = pending_frames.pop_front();
            req_valid     <= 1'b1;
            req_high_bits <= nxt.hi;
            req_low_bits  <= nxt.lo;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 12);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: changes its stall pattern now and then, with two long hold-offs.
   always @(posedge clock) begin : stall_proc
      logic ready_next;
      if (reset) begin
         rsp_ready <= 1'b0;
         long_hold <= 1'b0;
      end else begin
         stall_cycles++;
         if (hold_left == 0 && ((holds_done == 0 && stall_cycles >= 200) ||
                                (holds_done == 1 && stall_cycles >= 600))) begin
            hold_left = HOLD_CYCLES;
            holds_done++;
         end
         if (pattern_left == 0) begin
            pattern_mode = stall_mode_type'($urandom_range(0, 3));
            pattern_left = $urandom_range(10, 60);
            ready_mask   = 8'($urandom);
         end else begin
            pattern_left--;
         end
         case (pattern_mode)
            ALWAYS_READY:   ready_next = 1'b1;
            COIN_FLIP:      ready_next = 1'($urandom_range(0, 1));
            MOSTLY_STALLED: ready_next = ($urandom_range(0, 3) == 0);
            default: begin
               ready_next = ready_mask[0];
               ready_mask = {ready_mask[0], ready_mask[7:1]};
            end
         endcase
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end
         rsp_ready <= ready_next;
         long_hold <= (hold_left > 0);
      end
   end

   // Monitor: compares every accepted result word with the oldest prediction.
   always @(posedge clock) begin : check_proc
      decode_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_decodes.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("%0t: result word with no prediction, expected none, actual code %0d",
                        $time, rsp_code);
         end else begin
            want = predicted_decodes.pop_front();
            check_field("decode_failed", 16'(want.failed), 16'(rsp_decode_failed));
            check_field("code", 16'(want.code), 16'(rsp_code));
            check_field("agree_count", 16'(want.agree), 16'(rsp_agree_count));
            check_field("speed_limit", 16'(want.speed), 16'(rsp_speed_limit));
         end
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      frame_type f;
      int        shift, n_valid, n_agree, pick, k;

      // Directed frames: empty and full frames fail on non-codeword bytes.
      f.hi = '0;
      f.lo = '0;
      pending_frames.push_back(f);
      f.hi = '1;
      f.lo = '1;
      pending_frames.push_back(f);
      f.hi = '1;
      f.lo = '0;
      pending_frames.push_back(f);
      // Code zero in every group, and the all-ones code that maps to 500.
      pending_frames.push_back(build_frame(0, 0, 0, 5, 1'b0, 1'b0));
      pending_frames.push_back(build_frame(0, 15, 15, 5, 1'b0, 1'b0));
      // The table entry that holds a zero speed.
      pending_frames.push_back(build_frame(0, 5, 3, 3, 1'b0, 1'b0));
      // Largest shift, and a shift of one with the bare minimum of agreement.
      pending_frames.push_back(build_frame(7, 9, 6, 4, 1'b0, 1'b0));
      pending_frames.push_back(build_frame(1, 2, 12, 2, 1'b0, 1'b0));
      // A single valid group is not enough.
      pending_frames.push_back(build_frame(0, 4, 7, 1, 1'b0, 1'b0));

      // The first valid group disagrees with the two that follow it.
      f.hi = '0;
      f.lo = '0;
      f.hi = put_byte(f.hi, 0, CODEWORD[3]);
      f.lo = put_byte(f.lo, 0, CODEWORD[8]);
      for (int g = 1; g < 3; g++) begin
         f.hi = put_byte(f.hi, g * GROUP_BITS, CODEWORD[10]);
         f.lo = put_byte(f.lo, g * GROUP_BITS, CODEWORD[1]);
      end
      pending_frames.push_back(f);

      // A group with a valid high byte but a non-codeword low byte is skipped.
      f.hi = '0;
      f.lo = '0;
      for (int g = 0; g < 3; g++) begin
         f.hi = put_byte(f.hi, g * GROUP_BITS, CODEWORD[6]);
         f.lo = put_byte(f.lo, g * GROUP_BITS, (g == 1) ? 8'h00 : CODEWORD[11]);
      end
      pending_frames.push_back(f);

      // Group zero filled at the unshifted place while the others sit at shift two.
      f = build_frame(2, 13, 14, 2, 1'b0, 1'b0);
      f.hi = put_byte(f.hi, 0, CODEWORD[13]);
      f.lo = put_byte(f.lo, 0, CODEWORD[14]);
      pending_frames.push_back(f);

      // Every shift once, on a random background.
      for (int s = 0; s < SHIFTS; s++)
         pending_frames.push_back(build_frame(s, 2 * s + 1, 14 - s, 2 + s % 3, 1'b1, 1'b1));

      // Random part: mostly well-formed frames, mixed with broken ones and noise.
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         pick    = $urandom_range(0, 99);
         shift   = $urandom_range(0, SHIFTS - 1);
         n_valid = NGROUPS - ((shift > 0) ? 1 : 0);
         if (pick < 75) begin
            n_agree = $urandom_range(MIN_AGREE, n_valid);
            f = build_frame(shift, $urandom_range(0, 15), $urandom_range(0, 15), n_agree,
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 3) != 0));
         end else if (pick < 90) begin
            n_agree = $urandom_range(1, n_valid);
            f = build_frame(shift, $urandom_range(0, 15), $urandom_range(0, 15), n_agree,
                            1'($urandom_range(0, 1)), 1'b1);
            k = $urandom_range(0, SYM - 1);
            if ($urandom_range(0, 1) == 1) f.hi[k] = ~f.hi[k];
            else f.lo[k] = ~f.lo[k];
         end else begin
            f.hi = random_symbols();
            f.lo = random_symbols();
         end
         pending_frames.push_back(f);
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Drain: everything sent, everything answered, then a quiet wait before the verdict.
      while (pending_frames.size() > 0 || req_valid || predicted_decodes.size() > 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
